// ===== hdl/sbd_pkg.sv =====
// Shared types and constants for the sound burst detector.
package sbd_pkg;

    localparam int MAX_BLOCK       = 256;
    localparam int CAL_BLOCKS      = 200;
    localparam int LEVEL_FRAC_BITS = 8;

    localparam int FILL_W   = 9;
    localparam int SIDX_W   = 8;
    localparam int LIDX_W   = 8;
    localparam int LEVEL_W  = 24;
    localparam int DIV_W    = 32;
    localparam int DSR_W    = 9;
    localparam int DCNT_W   = 5;

    // divide by five as a multiply by ceil(2^28 / 5); exact below 2^25
    localparam int FIVE_SHIFT = 28;
    localparam int PROD_W     = LEVEL_W + FIVE_SHIFT;

    localparam logic [LEVEL_W:0]  MARGIN     = 25'(10 << LEVEL_FRAC_BITS);
    localparam logic [FILL_W-1:0] CAL_LAST   = 9'(CAL_BLOCKS - 1);
    localparam logic [LIDX_W-1:0] TAKEN_LAST = 8'(CAL_BLOCKS - 1);
    localparam logic [PROD_W-1:0] FIVE_RECIP = PROD_W'(53687092);

    typedef enum logic [1:0] {
        REG_MODE      = 2'd0,
        REG_MIN_GAP   = 2'd1,
        REG_INIT_THR  = 2'd2,
        REG_NONE      = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        SCAN_NONE = 2'd0,
        SCAN_DEV  = 2'd1,
        SCAN_MAX  = 2'd2,
        SCAN_SUM  = 2'd3
    } scan_op_t;

    typedef enum logic [1:0] {
        DIV_MEAN  = 2'd0,
        DIV_LEVEL = 2'd1,
        DIV_AVG   = 2'd2
    } div_sel_t;

    typedef enum logic [2:0] {
        LAT_NONE  = 3'd0,
        LAT_MEAN  = 3'd1,
        LAT_LEVEL = 3'd2,
        LAT_AVG   = 3'd3,
        LAT_THR   = 3'd4
    } latch_t;

    typedef enum logic [4:0] {
        ST_LOAD,
        ST_MEAN_GO,
        ST_MEAN_WAIT,
        ST_DEV,
        ST_DEV_END,
        ST_LVL_GO,
        ST_LVL_WAIT,
        ST_DECIDE,
        ST_MAX,
        ST_MAX_END,
        ST_SUM,
        ST_SUM_END,
        ST_SUM_CHK,
        ST_AVG_GO,
        ST_AVG_WAIT,
        ST_FIVE_GO,
        ST_FIVE_WAIT,
        ST_FAIL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic     take;
        logic     acc_clr;
        scan_op_t scan_op;
        logic     div_start;
        div_sel_t div_sel;
        latch_t   latch;
        logic     decide;
        logic     fail;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic scan_end;
        logic mode;
        logic cal_full;
        logic cnt_zero;
        logic out_free;
    } status_t;

endpackage

// ===== hdl/sound_burst_detector_with_holdoff_unit.sv =====
// Top level of the sound burst detector with hold-off and calibration.
//
// Input stream: one signed 16-bit sample per word; s_tlast closes a block and
// the time stamp of that word is used for the hold-off test. Samples load one
// per cycle while the unit is in its load state; beyond 256 samples a block's
// extra samples are dropped. After the closing word the block is processed:
// a divide for the mean, one pass over the stored samples (one per cycle) and
// a divide for the level; then the result word is loaded, and only after that
// is the next block's first word taken.
// In calibrate mode the 200th block adds two passes over all 200 entries of
// the level store, one more divide and a multiply by the reciprocal of five;
// when the calibration fails, the divide and the multiply are skipped.
// One result word per block leaves on the m_ channel; it is held in an output
// register, and while the receiver stalls the block keeps the next block out
// only once that block's result is ready to be loaded.
// The shared bit-serial divider and the single read port of each store set
// the pace of this work. Reset clears the counters, the hold-off time and the
// learned threshold; the user must write configuration only between blocks,
// as the block itself does not enforce it.
module sound_burst_detector_with_holdoff_unit
    import sbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // sample[15:0], time_ms[47:16]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    // burst_found[0], block_level[24:1], calibration_done[25],
    // calibration_failed[26], threshold_now[50:27], zero pad above
    output logic [55:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata
);

    cmd_t    cmd;
    status_t status;

    sbd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    sbd_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

// ===== hdl/sbd_ram.sv =====
// Generic single write port RAM with registered read.
module sbd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/sbd_div.sv =====
// Restoring divider, one quotient bit per cycle.
module sbd_div
    import sbd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic             done
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]  quo_reg, quo_next;
    logic [DSR_W-1:0]  rem_reg, rem_next;
    logic [DSR_W-1:0]  dsr_reg, dsr_next;
    logic [DSR_W:0]    rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg, quo_reg[DIV_W-1]};
    assign fits   = rem_sh >= {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIV_W-2:0], fits};
            rem_next = fits ? DSR_W'(rem_sh - {1'b0, dsr_reg}) : rem_sh[DSR_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(DIV_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== hdl/sbd_ctrl.sv =====
// Sequencing state machine for block load, level, detection and calibration.
module sbd_ctrl
    import sbd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  logic    s_tlast,
    output logic    s_tready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:      if (s_tvalid && s_tlast) state_next = ST_MEAN_GO;
            ST_MEAN_GO:   state_next = ST_MEAN_WAIT;
            ST_MEAN_WAIT: if (status.div_done) state_next = ST_DEV;
            ST_DEV:       if (status.scan_end) state_next = ST_DEV_END;
            ST_DEV_END:   state_next = ST_LVL_GO;
            ST_LVL_GO:    state_next = ST_LVL_WAIT;
            ST_LVL_WAIT:  if (status.div_done) state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (status.mode && status.cal_full) state_next = ST_MAX;
                else state_next = ST_OUT;
            end
            ST_MAX:       if (status.scan_end) state_next = ST_MAX_END;
            ST_MAX_END:   state_next = ST_SUM;
            ST_SUM:       if (status.scan_end) state_next = ST_SUM_END;
            ST_SUM_END:   state_next = ST_SUM_CHK;
            ST_SUM_CHK:   state_next = status.cnt_zero ? ST_FAIL : ST_AVG_GO;
            ST_AVG_GO:    state_next = ST_AVG_WAIT;
            ST_AVG_WAIT:  if (status.div_done) state_next = ST_FIVE_GO;
            // ST_FIVE_GO registers the product, ST_FIVE_WAIT adds it to the mean
            ST_FIVE_GO:   state_next = ST_FIVE_WAIT;
            ST_FIVE_WAIT: state_next = ST_OUT;
            ST_FAIL:      state_next = ST_OUT;
            ST_OUT:       if (status.out_free) state_next = ST_LOAD;
            default:      state_next = ST_LOAD;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.scan_op  = SCAN_NONE;
        cmd.div_sel  = DIV_MEAN;
        cmd.latch    = LAT_NONE;
        s_tready     = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                cmd.take = s_tvalid;
            end
            ST_MEAN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_MEAN;
                cmd.acc_clr   = 1'b1;
            end
            ST_MEAN_WAIT: cmd.latch   = LAT_MEAN;
            ST_DEV:       cmd.scan_op = SCAN_DEV;
            ST_LVL_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_LEVEL;
            end
            ST_LVL_WAIT:  cmd.latch   = LAT_LEVEL;
            ST_DECIDE: begin
                cmd.decide  = 1'b1;
                cmd.acc_clr = 1'b1;
            end
            ST_MAX:       cmd.scan_op = SCAN_MAX;
            ST_SUM:       cmd.scan_op = SCAN_SUM;
            ST_AVG_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_AVG;
            end
            ST_AVG_WAIT:  cmd.latch    = LAT_AVG;
            ST_FIVE_WAIT: cmd.latch    = LAT_THR;
            ST_FAIL:      cmd.fail     = 1'b1;
            ST_OUT:       cmd.out_load = status.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/sbd_datapath.sv =====
// Datapath: sample and level stores, accumulators, divider and result register.
module sbd_datapath
    import sbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_wdata,
    input  cmd_t        cmd,
    output status_t     status
);

    // configuration
    logic                mode_reg;
    logic [15:0]         gap_reg;
    logic [LEVEL_W-1:0]  init_thr_reg;

    logic [FILL_W-1:0]   fill_reg;
    logic signed [24:0]  sum_reg;
    logic [31:0]         time_reg;
    logic signed [15:0]  mean_reg;
    logic [24:0]         dev_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic [LIDX_W-1:0]   taken_reg;
    logic [LEVEL_W-1:0]  mx_reg;
    logic [31:0]         lsum_reg;
    logic [LIDX_W-1:0]   cnt_reg;
    logic [LEVEL_W-1:0]  avg_reg;
    logic [LEVEL_W-1:0]  fifth_reg;
    logic [LEVEL_W-1:0]  learned_reg;
    logic                learned_valid_reg;
    logic [31:0]         last_burst_reg;
    logic                burst_reg, done_reg, failed_reg;
    logic [FILL_W-1:0]   scan_idx_reg;
    scan_op_t            scan_d_reg;
    logic                out_valid_reg;
    logic [55:0]         out_data_reg;

    logic signed [15:0]  s_sample;
    logic [15:0]         sram_rd;
    logic [LEVEL_W-1:0]  lram_rd;
    logic                div_done;
    logic [DIV_W-1:0]    quo;
    logic [DIV_W-1:0]    div_dvd;
    logic [DSR_W-1:0]    div_dsr;
    logic [23:0]         sum_mag;
    logic signed [16:0]  diff;
    logic [16:0]         diff_abs;
    logic [LEVEL_W-1:0]  thr;
    logic [LEVEL_W:0]    span2;
    logic [PROD_W-1:0]   five_prod;
    logic                sample_we;

    assign s_sample  = s_tdata[15:0];
    assign sample_we = cmd.take && !fill_reg[FILL_W-1];
    assign sum_mag   = sum_reg[24] ? 24'(-sum_reg) : sum_reg[23:0];
    assign thr       = learned_valid_reg ? learned_reg : init_thr_reg;
    assign span2     = {mx_reg - avg_reg, 1'b0};
    assign five_prod = PROD_W'(span2) * FIVE_RECIP;

    sbd_ram #(.WIDTH(16), .DEPTH(MAX_BLOCK)) u_sample_ram (
        .aclk  (aclk),
        .we    (sample_we),
        .waddr (fill_reg[SIDX_W-1:0]),
        .wdata (s_sample),
        .raddr (scan_idx_reg[SIDX_W-1:0]),
        .rdata (sram_rd)
    );

    sbd_ram #(.WIDTH(LEVEL_W), .DEPTH(CAL_BLOCKS)) u_level_ram (
        .aclk  (aclk),
        .we    (cmd.decide && mode_reg),
        .waddr (taken_reg),
        .wdata (level_reg),
        .raddr (scan_idx_reg[LIDX_W-1:0]),
        .rdata (lram_rd)
    );

    always_comb begin
        unique case (cmd.div_sel)
            DIV_MEAN: begin
                div_dvd = {8'd0, sum_mag};
                div_dsr = fill_reg;
            end
            DIV_LEVEL: begin
                div_dvd = {dev_reg[23:0], 8'd0};
                div_dsr = fill_reg;
            end
            DIV_AVG: begin
                div_dvd = lsum_reg;
                div_dsr = {1'b0, cnt_reg};
            end
            default: begin
                div_dvd = '0;
                div_dsr = '0;
            end
        endcase
    end

    sbd_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quotient (quo),
        .done     (div_done)
    );

    assign diff     = {sram_rd[15], sram_rd} - {mean_reg[15], mean_reg};
    assign diff_abs = diff[16] ? 17'(-diff) : diff;

    always_comb begin
        status.div_done = div_done;
        status.mode     = mode_reg;
        status.cal_full = taken_reg == TAKEN_LAST;
        status.cnt_zero = cnt_reg == '0;
        status.out_free = !out_valid_reg || m_tready;
        if (cmd.scan_op == SCAN_DEV) status.scan_end = scan_idx_reg == fill_reg - 1'b1;
        else status.scan_end = scan_idx_reg == CAL_LAST;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= 1'b0;
            gap_reg           <= 16'd300;
            init_thr_reg      <= '0;
            fill_reg          <= '0;
            sum_reg           <= '0;
            last_burst_reg    <= '0;
            taken_reg         <= '0;
            learned_reg       <= '0;
            learned_valid_reg <= 1'b0;
            scan_idx_reg      <= '0;
            scan_d_reg        <= SCAN_NONE;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (reg_index_t'(cfg_index))
                    REG_MODE: begin
                        mode_reg  <= cfg_wdata[0];
                        taken_reg <= '0;
                    end
                    REG_MIN_GAP:  gap_reg      <= cfg_wdata[15:0];
                    REG_INIT_THR: init_thr_reg <= cfg_wdata;
                    REG_NONE: ;
                    default: ;
                endcase
            end
            // samples beyond the store depth are dropped
            if (sample_we) begin
                fill_reg <= fill_reg + 1'b1;
                sum_reg  <= sum_reg + 25'(s_sample);
            end
            scan_idx_reg <= (cmd.scan_op != SCAN_NONE) ? scan_idx_reg + 1'b1 : '0;
            scan_d_reg   <= cmd.scan_op;
            if (cmd.decide && mode_reg) begin
                taken_reg <= (taken_reg == TAKEN_LAST) ? '0 : taken_reg + 1'b1;
            end
            if (cmd.decide && !mode_reg && level_reg > thr
                && time_reg > last_burst_reg + {16'd0, gap_reg}) begin
                last_burst_reg <= time_reg;
            end
            if (cmd.latch == LAT_THR) begin
                learned_reg       <= avg_reg + fifth_reg;
                learned_valid_reg <= 1'b1;
            end
            if (cmd.out_load) begin
                fill_reg      <= '0;
                sum_reg       <= '0;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            time_reg <= s_tdata[47:16];
        end
        fifth_reg <= five_prod[PROD_W-1:FIVE_SHIFT];
        if (cmd.acc_clr) begin
            dev_reg  <= '0;
            mx_reg   <= '0;
            lsum_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            unique case (scan_d_reg)
                SCAN_DEV: dev_reg <= dev_reg + 25'(diff_abs);
                SCAN_MAX: if (lram_rd > mx_reg) mx_reg <= lram_rd;
                SCAN_SUM: begin
                    if ({1'b0, lram_rd} + MARGIN < {1'b0, mx_reg}) begin
                        lsum_reg <= lsum_reg + 32'(lram_rd);
                        cnt_reg  <= cnt_reg + 1'b1;
                    end
                end
                SCAN_NONE: ;
                default: ;
            endcase
        end
        if (div_done) begin
            unique case (cmd.latch)
                LAT_MEAN:  mean_reg  <= sum_reg[24] ? 16'(-quo) : quo[15:0];
                LAT_LEVEL: level_reg <= (quo[DIV_W-1:LEVEL_W] != '0) ? '1 : quo[LEVEL_W-1:0];
                LAT_AVG:   avg_reg   <= quo[LEVEL_W-1:0];
                LAT_THR: ;
                LAT_NONE: ;
                default: ;
            endcase
        end
        if (cmd.decide) begin
            burst_reg  <= !mode_reg && level_reg > thr
                          && time_reg > last_burst_reg + {16'd0, gap_reg};
            done_reg   <= mode_reg && taken_reg == TAKEN_LAST;
            failed_reg <= 1'b0;
        end
        if (cmd.fail) begin
            failed_reg <= 1'b1;
        end
        if (cmd.out_load) begin
            out_data_reg <= {5'd0, thr, failed_reg, done_reg, level_reg, burst_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FILL_W'(MAX_BLOCK))
        else $error("fill count beyond store depth");
    a_taken_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        taken_reg <= TAKEN_LAST)
        else $error("calibration count beyond run length");
    a_learned_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        learned_valid_reg |=> learned_valid_reg)
        else $error("learned threshold lost its validity");
    a_no_take_on_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !cmd.take && !cmd.div_start)
        else $error("output load overlaps block work");
`endif

endmodule

// ===== tb/sound_burst_detector_with_holdoff_unit_tb.sv =====
// Self-checking testbench for the sound burst detector with hold-off and calibration.
module sound_burst_detector_with_holdoff_unit_tb;
    import sbd_pkg::*;

    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic [23:0] thr;
        logic        failed;
        logic        done;
        logic [23:0] level;
        logic        burst;
    } block_result_t;

    class level_scoreboard;
        bit          mode;
        bit [15:0]   min_gap;
        bit [23:0]   init_thr;
        shortint     samples[MAX_BLOCK];
        int          fill;
        longint      acc;
        bit [31:0]   last_burst;
        bit [23:0]   cal_levels[CAL_BLOCKS];
        int          taken;
        bit [23:0]   learned;
        bit          learned_ok;
        int          errors;
        block_result_t pending_results[$];

        function new();
            mode = 1'b0; min_gap = 16'd300; init_thr = '0;
            fill = 0; acc = 0; last_burst = '0; taken = 0;
            learned = '0; learned_ok = 1'b0; errors = 0;
        endfunction

        function void write_reg(reg_index_t idx, bit [23:0] val);
            case (idx)
                REG_MODE: begin
                    mode = val[0];
                    taken = 0;
                end
                REG_MIN_GAP:  min_gap = val[15:0];
                REG_INIT_THR: init_thr = val;
                default: ;
            endcase
        endfunction

        function bit [23:0] block_level();
            longint mean;
            longint d;
            longint unsigned dev;
            longint unsigned lvl;
            mean = acc / fill;
            dev = 0;
            for (int i = 0; i < fill; i++) begin
                d = longint'(samples[i]) - mean;
                dev += (d < 0) ? -d : d;
            end
            lvl = (dev << LEVEL_FRAC_BITS) / fill;
            return (lvl > 64'hFFFFFF) ? 24'hFFFFFF : lvl[23:0];
        endfunction

        function bit learn();
            longint unsigned mx, sum, cnt, mean, thr;
            mx = 0; sum = 0; cnt = 0;
            foreach (cal_levels[i]) if (cal_levels[i] > mx) mx = cal_levels[i];
            foreach (cal_levels[i])
                if (longint'(cal_levels[i]) + (10 << LEVEL_FRAC_BITS) < mx) begin
                    sum += cal_levels[i];
                    cnt++;
                end
            if (cnt == 0) return 1'b0;
            mean = sum / cnt;
            thr = mean + ((mx - mean) * 2) / 5;
            learned = thr[23:0];
            learned_ok = 1'b1;
            return 1'b1;
        endfunction

        function void note_sample(logic signed [15:0] s, logic last, logic [31:0] stamp);
            block_result_t r;
            if (fill < MAX_BLOCK) begin
                samples[fill] = s;
                acc += s;
                fill++;
            end
            if (!last) return;
            r = '0;
            r.level = block_level();
            fill = 0;
            acc = 0;
            if (!mode) begin
                if (r.level > (learned_ok ? learned : init_thr) &&
                    stamp > 32'(last_burst + min_gap)) begin
                    last_burst = stamp;
                    r.burst = 1'b1;
                end
            end else begin
                if (taken < CAL_BLOCKS) cal_levels[taken] = r.level;
                taken++;
                if (taken >= CAL_BLOCKS) begin
                    taken = 0;
                    r.done = 1'b1;
                    r.failed = !learn();
                end
            end
            r.thr = learned_ok ? learned : init_thr;
            pending_results.push_back(r);
        endfunction

        function void check_word(logic [55:0] word);
            block_result_t got, want;
            got = word[50:0];
            if (pending_results.size() == 0) begin
                $error("unexpected result word %h", word);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.burst !== want.burst) begin
                $error("burst_found: expected %0d, got %0d", want.burst, got.burst);
                errors++;
            end
            if (got.level !== want.level) begin
                $error("block_level: expected %0d, got %0d", want.level, got.level);
                errors++;
            end
            if (got.done !== want.done) begin
                $error("calibration_done: expected %0d, got %0d", want.done, got.done);
                errors++;
            end
            if (got.failed !== want.failed) begin
                $error("calibration_failed: expected %0d, got %0d", want.failed, got.failed);
                errors++;
            end
            if (got.thr !== want.thr) begin
                $error("threshold_now: expected %0d, got %0d", want.thr, got.thr);
                errors++;
            end
            if (word[55:51] !== '0) begin
                $error("pad: expected 0, got %0d", word[55:51]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // sample[15:0], time_ms[47:16]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // burst_found, block_level, calibration_done, ..._failed, threshold_now
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [23:0] cfg_wdata;

    level_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int quiet_cycles;
    int block_count;

    sound_burst_detector_with_holdoff_unit uut (.*);

    always begin
        aclk = 1'b1; #1;
        aclk = 1'b0; #1;
    end

    initial begin
        sb = new();
        idle_pct = 0;
        stall_pct = 0;
        quiet_cycles = 0;
        block_count = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_MODE;
        cfg_wdata = '0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_sample(s_tdata[15:0], s_tlast, s_tdata[47:16]);
            if (m_tvalid && m_tready) sb.check_word(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // rotate idling every 20 blocks: none, sender, receiver, both
    task automatic pick_pressure();
        case ((block_count / 20) % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 82; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 82; end
            default: begin idle_pct = 29; stall_pct = 29; end
        endcase
    endtask

    task automatic send_word(logic [15:0] s, logic last, logic [31:0] stamp);
        while ($urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {stamp, s};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // amplitude 0: full range, otherwise samples within +/- amp
    task automatic send_block(int len, int amp, logic [31:0] stamp);
        logic [15:0] s;
        pick_pressure();
        for (int i = 0; i < len; i++) begin
            if (amp == 0) s = 16'($urandom);
            else s = 16'($signed($urandom_range(2 * amp)) - amp);
            send_word(s, i == len - 1, (i == len - 1) ? stamp : 32'($urandom));
        end
        block_count++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;
        @(posedge aclk);
        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge aclk);
    endtask

    initial begin
        logic [31:0] stamp;
        #0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, hold-off boundary, truncation toward zero
        send_word(16'h7FFF, 1'b1, 32'd1000);
        for (int i = 0; i < 4; i++) send_word(16'h8000, 1'b0, 32'hFFFF_FFFF);
        for (int i = 0; i < 3; i++) send_word(16'h7FFF, 1'b0, 32'd0);
        send_word(16'h7FFF, 1'b1, 32'd0);
        send_word(16'h8000, 1'b0, 32'd5);
        send_word(16'h7FFF, 1'b1, 32'd301);
        send_word(16'h8000, 1'b0, 32'd5);
        send_word(16'h7FFF, 1'b1, 32'd601);
        send_word(16'h8000, 1'b0, 32'd5);
        send_word(16'h7FFF, 1'b1, 32'd602);
        send_word(16'hFFFF, 1'b0, 32'd0);
        send_word(16'h0000, 1'b1, 32'd0);
        send_word(16'hFFFD, 1'b0, 32'd0);
        send_word(16'h0000, 1'b0, 32'd0);
        send_word(16'h0000, 1'b1, 32'hFFFF_FFFF);
        drain();

        write_reg(REG_MIN_GAP, 24'd0);
        write_reg(REG_INIT_THR, 24'hFFFFFF);
        for (int b = 0; b < 50; b++) send_block($urandom_range(1, 6), 0, $urandom);
        drain();

        write_reg(REG_MIN_GAP, 24'hFFFF);
        write_reg(REG_INIT_THR, 24'd0);
        send_block(300, 0, 32'h8000_0000);
        for (int b = 0; b < 50; b++)
            send_block($urandom_range(1, 6), ($urandom_range(1) ? 0 : 300), $urandom);
        drain();

        // calibration over constant blocks: every level equal, so it fails
        write_reg(REG_MIN_GAP, 24'd250);
        write_reg(REG_MODE, 24'd1);
        for (int b = 0; b < CAL_BLOCKS; b++) send_block(1, 0, $urandom);
        drain();

        // part of a run, then restart it by rewriting the mode
        for (int b = 0; b < 30; b++) send_block(2, 0, $urandom);
        drain();
        write_reg(REG_MODE, 24'd1);
        for (int b = 0; b < CAL_BLOCKS; b++)
            send_block(2, ($urandom_range(9) == 0) ? 0 : 200, $urandom);
        drain();

        // detect against the learned threshold with non-decreasing time stamps
        write_reg(REG_MODE, 24'd0);
        stamp = $urandom_range(1000);
        for (int b = 0; b < 50; b++) begin
            stamp += $urandom_range(600);
            send_block($urandom_range(1, 6), ($urandom_range(2) == 0) ? 0 : 100, stamp);
        end
        drain();

        if (sb.errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
